// ----- design/bdhr_pkg.sv -----
// Package for the button debounce / hold / repeat block.
// Shared constants, event codes and the configuration struct; no dependencies.
`default_nettype none
package bdhr_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int BTN_W       = 3;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd100;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RESET   = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_REPEAT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_PRESSED  = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_HELD     = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic [BTN_W-1:0]  button_index;
    logic              raw_level;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic        valid;
    event_kind_t kind;
  } event_t;

endpackage
`default_nettype wire

// ----- design/bdhr_cfg.sv -----
// Configuration registers: debounce, hold and repeat times.
// Depends on bdhr_pkg.
`default_nettype none
module bdhr_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [bdhr_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [bdhr_pkg::CFG_W-1:0]     wr_data,
  output bdhr_pkg::cfg_t                      cfg
);

  bdhr_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms <= bdhr_pkg::DEBOUNCE_RESET;
      regs.hold_ms     <= bdhr_pkg::HOLD_RESET;
      regs.repeat_ms   <= bdhr_pkg::REPEAT_RESET;
    end else if (wr_en) begin
      case (wr_index)
        bdhr_pkg::REG_DEBOUNCE: regs.debounce_ms <= wr_data;
        bdhr_pkg::REG_HOLD:     regs.hold_ms     <= wr_data;
        bdhr_pkg::REG_REPEAT:   regs.repeat_ms   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

// ----- design/bdhr_btn.sv -----
// Per-button state (accepted level, last change time, repeat count) and the
// event decision for one registered sample. Depends on bdhr_pkg.
`default_nettype none
module bdhr_btn (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             commit,
  input  wire bdhr_pkg::sample_t sample,
  input  wire bdhr_pkg::cfg_t    cfg,
  output bdhr_pkg::event_t      ev
);

  logic                          level_arr [bdhr_pkg::NUM_BUTTONS];
  logic [bdhr_pkg::TIME_W-1:0]   last_arr  [bdhr_pkg::NUM_BUTTONS];
  logic [bdhr_pkg::CNT_W-1:0]    count_arr [bdhr_pkg::NUM_BUTTONS];

  logic                          in_range;
  logic                          cur_level;
  logic [bdhr_pkg::TIME_W-1:0]   elapsed;
  logic [bdhr_pkg::CNT_W-1:0]    cur_count;
  logic [bdhr_pkg::CNT_W+bdhr_pkg::CFG_W-1:0] prod;
  logic [bdhr_pkg::TIME_W-1:0]   hold_w;
  logic [bdhr_pkg::TIME_W-1:0]   past_hold;
  logic                          change;
  logic                          held;

  assign in_range  = 32'(sample.button_index) < bdhr_pkg::NUM_BUTTONS;
  assign cur_level = level_arr[sample.button_index];
  assign cur_count = count_arr[sample.button_index];
  assign elapsed   = sample.now_ms - last_arr[sample.button_index];
  assign hold_w    = {{(bdhr_pkg::TIME_W-bdhr_pkg::CFG_W){1'b0}}, cfg.hold_ms};

  // elapsed > hold + count*repeat, rewritten as (elapsed - hold) > count*repeat
  assign prod      = {{bdhr_pkg::CFG_W{1'b0}}, cur_count} *
                     {{bdhr_pkg::CNT_W{1'b0}}, cfg.repeat_ms};
  assign past_hold = elapsed - hold_w;

  assign change = in_range && (sample.raw_level != cur_level) &&
                  (elapsed > {{(bdhr_pkg::TIME_W-bdhr_pkg::CFG_W){1'b0}}, cfg.debounce_ms});
  assign held   = in_range && (sample.raw_level == cur_level) && !cur_level &&
                  (elapsed > hold_w) &&
                  ({{bdhr_pkg::CFG_W{1'b0}}, past_hold} > prod);

  always_comb begin
    ev.valid = change || held;
    if (held) begin
      ev.kind = bdhr_pkg::KIND_HELD;
    end else if (sample.raw_level) begin
      ev.kind = bdhr_pkg::KIND_RELEASED;
    end else begin
      ev.kind = bdhr_pkg::KIND_PRESSED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < bdhr_pkg::NUM_BUTTONS; b++) begin
        level_arr[b] <= 1'b1;
        last_arr[b]  <= '0;
        count_arr[b] <= '0;
      end
    end else if (commit) begin
      if (change) begin
        level_arr[sample.button_index] <= sample.raw_level;
        last_arr[sample.button_index]  <= sample.now_ms;
        count_arr[sample.button_index] <= '0;
      end else if (held) begin
        count_arr[sample.button_index] <= cur_count + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/button_debounce_hold_repeat.sv -----
// Top level of the button debounce / hold / repeat block.
// Depends on bdhr_pkg, bdhr_cfg and bdhr_btn.
`default_nettype none
// Takes one button sample per word and emits at most one event word per
// sample: pressed, released (after debounce) or held/repeat while pressed.
// A sample is registered on entry, evaluated against the per-button state
// and the result lands in the output register; one sample can be taken
// every cycle while the output register is not stalled. The per-button
// state is updated in the same cycle the event is decided, so samples of the
// same button may follow back to back. The only stall comes from a full
// output register that is not being taken. Config writes are always ready.
module button_debounce_hold_repeat (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [2:0] button_index, [3] raw_level, [35:4] now_ms, [39:36] zero
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] event_button, [4:3] event_kind, [7:5] zero
  output logic [7:0]       m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [bdhr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdhr_pkg::CFG_W-1:0]     cfg_data
);

  bdhr_pkg::cfg_t       cfg;
  bdhr_pkg::sample_t    sample;
  bdhr_pkg::event_t     ev;
  logic                 sample_valid;
  logic                 out_free;
  logic                 adv;
  logic [bdhr_pkg::BTN_W-1:0] out_button;
  bdhr_pkg::event_kind_t      out_kind;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign adv       = sample_valid && out_free;
  assign s_tready  = !sample_valid || out_free;

  bdhr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bdhr_btn u_btn (
    .clk    (clk),
    .rst    (rst),
    .commit (adv),
    .sample (sample),
    .cfg    (cfg),
    .ev     (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (s_tready) begin
      sample_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      sample.button_index <= s_tdata[2:0];
      sample.raw_level    <= s_tdata[3];
      sample.now_ms       <= s_tdata[35:4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= adv && ev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ev.valid) begin
      out_button <= sample.button_index;
      out_kind   <= ev.kind;
    end
  end

  assign m_tdata = {3'b000, out_kind, out_button};

`ifndef SYNTHESIS
  // an empty input stage always takes a word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !sample_valid |-> s_tready)
    else $error("input stage empty but not ready");

  // a new event word only appears after a sample was evaluated
  a_event_from_sample: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(adv))
    else $error("event word without an evaluated sample");

  // a blocked sample stays in the input stage
  a_sample_held: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !out_free |=> sample_valid && $stable(sample))
    else $error("blocked sample lost");
`endif

endmodule
`default_nettype wire
